### src/rpmd_pkg.sv
// ----------------------------------------------------------------------------
// Ramped PWM motor driver package
// Shared types and constants for the ramped PWM motor driver core.
// ----------------------------------------------------------------------------
`default_nettype none

package rpmd_pkg;

   // PWM timing and ramp constants.
   localparam int unsigned PWM_PERIOD        = 120;
   localparam int unsigned TICKS_PER_MS      = 1000;
   localparam int unsigned LEVEL_CAP         = 120;
   localparam int unsigned RATE_BASE         = 11;
   localparam int unsigned RAMP_DOWN_RATE    = 10;
   localparam int unsigned REVERSAL_LIMIT_MS = 2000;
   localparam int unsigned STOP_LIMIT_RESET  = 2000;
   localparam int unsigned US_PER_RATE_UNIT  = 2 * TICKS_PER_MS;

   // Field widths.
   localparam int unsigned LEVEL_W    = 7;
   localparam int unsigned PWM_POS_W  = 7;
   localparam int unsigned STEP_US_W  = 15;
   localparam int unsigned PRESCALE_W = 10;
   localparam int unsigned RUN_MS_W   = 20;
   localparam int unsigned STOP_MS_W  = 16;
   localparam int unsigned RATE_W     = 4;

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_TURN  = 2'd1,
      OP_STOP  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_REVERSE = 2'd1,
      PH_TURN    = 2'd2,
      PH_STOP    = 2'd3
   } phase_type;

   typedef enum logic {
      DIR_CW  = 1'b0,
      DIR_CCW = 1'b1
   } dir_type;

   typedef struct packed {
      logic                 busy_res;
      logic                 in_motion;
      logic [LEVEL_W-1:0]   power_level;
      logic                 ccw_drive;
      logic                 cw_drive;
   } rsp_type;

endpackage

`default_nettype wire

### src/ramped_pwm_motor_driver_core.sv
// ----------------------------------------------------------------------------
// Ramped PWM motor driver core
// Two-pin PWM motor drive with soft start, reversal ramp-down and timed stop.
//
//   Channel | Direction | Content
//   req_*   | in        | one microsecond tick, turn command or stop command
//   rsp_*   | out       | pin levels, power level and status, one per item
//   csr_*   | in        | stop ramp time limit in milliseconds
//
// For every item, the state update and the result are computed from the
// state registers and the incoming item, and the result is stored
// in the output register. A new item is taken in every cycle unless the
// output register holds a result that is not being taken. Reset is
// synchronous and returns the drive to idle with both pins low.
// ----------------------------------------------------------------------------
`default_nettype none

module ramped_pwm_motor_driver_core
   import rpmd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Configuration.
   input  wire logic                  csr_wr_en,
   input  wire logic [STOP_MS_W-1:0]  csr_wr_data,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tuser: operation[1:0]
   input  wire logic [1:0]            req_tuser,
   // tdata: cmd_direction[0], desired_speed[7:1], duration_ms[27:8],
   //        ramp_rate[31:28], quick_change[32], zero fill [39:33]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: cw_drive[0], ccw_drive[1], power_level[8:2], in_motion[9],
   //        busy_res[10], zero fill [15:11]
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   // State registers.
   logic [STOP_MS_W-1:0]  stop_limit_ff;
   logic [LEVEL_W-1:0]    power_ff,       power_in;
   logic                  last_dir_ff,    last_dir_in;
   logic [LEVEL_W-1:0]    target_ff,      target_in;
   logic                  cmd_dir_ff,     cmd_dir_in;
   phase_type             phase_ff,       phase_in;
   logic [PWM_POS_W-1:0]  pwm_pos_ff,     pwm_pos_in;
   logic [STEP_US_W-1:0]  step_us_ff,     step_us_in;
   logic [PRESCALE_W-1:0] prescale_ff,    prescale_in;
   logic [RUN_MS_W-1:0]   run_ms_ff,      run_ms_in;
   logic [STOP_MS_W-1:0]  stop_ms_ff,     stop_ms_in;
   logic [RATE_W-1:0]     rate_ff,        rate_in;
   logic                  motion_ff,      motion_in;
   logic                  rsp_valid_ff,   rsp_valid_in;
   rsp_type               rsp_ff,         rsp_in;

   // Request fields.
   op_type                req_op;
   logic                  req_dir;
   logic [LEVEL_W-1:0]    req_speed;
   logic [RUN_MS_W-1:0]   req_duration;
   logic [RATE_W-1:0]     req_rate;
   logic                  req_quick;
   logic                  req_accept;

   assign req_op       = op_type'(req_tuser);
   assign req_dir      = req_tdata[0];
   assign req_speed    = req_tdata[7:1];
   assign req_duration = req_tdata[27:8];
   assign req_rate     = req_tdata[31:28];
   assign req_quick    = req_tdata[32];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   function automatic rsp_type drive_out(input phase_type ph, input logic [LEVEL_W-1:0] lvl,
                                         input logic [PWM_POS_W-1:0] pos, input logic cdir,
                                         input logic ldir, input logic mot);
      rsp_type             r;
      logic                dir;
      logic [LEVEL_W-1:0]  on_time;
      logic                pin;
      dir     = (ph == PH_TURN) ? cdir : ldir;
      on_time = (lvl > LEVEL_W'(PWM_PERIOD)) ? LEVEL_W'(PWM_PERIOD) : lvl;
      pin     = (ph != PH_IDLE) && (pos < on_time);
      r.cw_drive    = (dir == DIR_CW)  ? pin : 1'b0;
      r.ccw_drive   = (dir == DIR_CCW) ? pin : 1'b0;
      r.power_level = lvl;
      r.in_motion   = mot;
      r.busy_res    = (ph != PH_IDLE);
      return r;
   endfunction

   always_comb begin
      logic                 run_step;
      logic [RATE_W-1:0]    step_rate;
      logic [STEP_US_W-1:0] step_len;
      logic                 start_step;

      power_in    = power_ff;
      last_dir_in = last_dir_ff;
      target_in   = target_ff;
      cmd_dir_in  = cmd_dir_ff;
      phase_in    = phase_ff;
      pwm_pos_in  = pwm_pos_ff;
      step_us_in  = step_us_ff;
      prescale_in = prescale_ff;
      run_ms_in   = run_ms_ff;
      stop_ms_in  = stop_ms_ff;
      rate_in     = rate_ff;
      motion_in   = motion_ff;
      run_step    = 1'b0;
      start_step  = 1'b0;
      step_rate   = (phase_ff == PH_TURN) ? rate_ff : RATE_W'(RAMP_DOWN_RATE);
      step_len    = STEP_US_W'((STEP_US_W'(RATE_BASE) - STEP_US_W'(step_rate))
                               * STEP_US_W'(US_PER_RATE_UNIT));

      // First stage: timers on a tick, setup on a command.
      case (req_op)
         OP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               pwm_pos_in = pwm_pos_ff + 1'b1;
               if (step_us_ff != '1) begin
                  step_us_in = step_us_ff + 1'b1;
               end
               prescale_in = prescale_ff + 1'b1;
               if (prescale_in >= PRESCALE_W'(TICKS_PER_MS)) begin
                  prescale_in = '0;
                  if (run_ms_ff != '0) begin
                     run_ms_in = run_ms_ff - 1'b1;
                  end
                  if (stop_ms_ff != '1) begin
                     stop_ms_in = stop_ms_ff + 1'b1;
                  end
               end
               if (pwm_pos_in >= PWM_POS_W'(PWM_PERIOD)) begin
                  pwm_pos_in = '0;
                  run_step   = (step_us_in >= step_len);
               end
            end
         end
         OP_TURN: begin
            if (phase_ff == PH_IDLE) begin
               cmd_dir_in  = req_dir;
               target_in   = (req_speed > LEVEL_W'(LEVEL_CAP)) ? LEVEL_W'(LEVEL_CAP)
                                                               : req_speed;
               rate_in     = (req_rate > RATE_W'(RAMP_DOWN_RATE)) ? RATE_W'(RAMP_DOWN_RATE)
                                                                  : req_rate;
               run_ms_in   = req_duration;
               prescale_in = '0;
               stop_ms_in  = '0;
               pwm_pos_in  = '0;
               step_us_in  = '0;
               if (!req_quick && (req_dir != last_dir_ff) && (power_ff != '0)) begin
                  phase_in = PH_REVERSE;
               end else begin
                  phase_in = PH_TURN;
               end
               run_step = 1'b1;
            end
         end
         OP_STOP: begin
            if ((phase_ff == PH_IDLE) && (power_ff != '0)) begin
               prescale_in = '0;
               stop_ms_in  = '0;
               pwm_pos_in  = '0;
               step_us_in  = '0;
               phase_in    = PH_STOP;
               run_step    = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Second stage: the ramp decision at a command or at a step boundary.
      // A finished reversal ramp-down falls through to the turn ramp.
      if (run_step) begin
         if (phase_in == PH_REVERSE) begin
            if ((stop_ms_in < STOP_MS_W'(REVERSAL_LIMIT_MS)) && (power_in != '0)) begin
               power_in   = power_in - 1'b1;
               start_step = 1'b1;
            end else begin
               motion_in = 1'b0;
               phase_in  = PH_TURN;
            end
         end
         if (!start_step) begin
            if (phase_in == PH_TURN) begin
               if (run_ms_in != '0) begin
                  if (power_in > target_in) begin
                     power_in = power_in - 1'b1;
                  end else if (power_in < target_in) begin
                     power_in = power_in + 1'b1;
                  end
                  start_step = 1'b1;
               end else begin
                  last_dir_in = cmd_dir_in;
                  phase_in    = PH_IDLE;
               end
            end else if (phase_in == PH_STOP) begin
               if ((stop_ms_in < stop_limit_ff) && (power_in != '0)) begin
                  power_in   = power_in - 1'b1;
                  start_step = 1'b1;
               end else begin
                  motion_in = 1'b0;
                  phase_in  = PH_IDLE;
               end
            end
         end
         if (start_step) begin
            motion_in  = 1'b1;
            step_us_in = '0;
            pwm_pos_in = '0;
         end
      end

      // A tick shows the pins it drives now; a command shows those of the next tick.
      if (req_op == OP_TICK) begin
         rsp_in = drive_out(phase_ff, power_ff, pwm_pos_ff, cmd_dir_ff, last_dir_ff,
                            motion_ff);
      end else begin
         rsp_in = drive_out(phase_in, power_in, pwm_pos_in, cmd_dir_in, last_dir_in,
                            motion_in);
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_limit_ff <= STOP_MS_W'(STOP_LIMIT_RESET);
         power_ff      <= '0;
         last_dir_ff   <= DIR_CW;
         target_ff     <= '0;
         cmd_dir_ff    <= DIR_CW;
         phase_ff      <= PH_IDLE;
         pwm_pos_ff    <= '0;
         step_us_ff    <= '0;
         prescale_ff   <= '0;
         run_ms_ff     <= '0;
         stop_ms_ff    <= '0;
         rate_ff       <= RATE_W'(RAMP_DOWN_RATE);
         motion_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            stop_limit_ff <= csr_wr_data;
         end
         if (req_accept) begin
            power_ff    <= power_in;
            last_dir_ff <= last_dir_in;
            target_ff   <= target_in;
            cmd_dir_ff  <= cmd_dir_in;
            phase_ff    <= phase_in;
            pwm_pos_ff  <= pwm_pos_in;
            step_us_ff  <= step_us_in;
            prescale_ff <= prescale_in;
            run_ms_ff   <= run_ms_in;
            stop_ms_ff  <= stop_ms_in;
            rate_ff     <= rate_in;
            motion_ff   <= motion_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(rsp_type))'(0), rsp_ff};

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Ramped PWM motor driver testbench
// Drives microsecond ticks, turn commands and stop commands into the core and
// predicts every result item from its own copy of the drive state. Directed
// items cover saturation, zero duration, a full ramp step with stray commands
// while busy, a stop cut short by the stop limit and a reversal ramp-down,
// while both channels idle and stall by a random draw for every item.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rpmd_pkg::*;

   localparam int unsigned MAX_GAP       = 19;
   localparam int unsigned MAX_RATE      = 10;
   localparam int unsigned SETTLE_CYCLES = 4;
   // Upper bound on items; each item may see both a full sender gap and a
   // full stall on the result side.
   localparam longint unsigned ITEM_BOUND  = 2400;
   localparam longint unsigned CYCLE_LIMIT = 4 * (2 * MAX_GAP + 2) * ITEM_BOUND;

   class drive_scoreboard;
      rsp_type              expected_pins[$];
      int unsigned          mismatches;
      int unsigned          ticks, commands, turns_started, stops_started;
      int unsigned          reversals, steps_taken;
      logic [STOP_MS_W-1:0] stop_limit;

      logic [LEVEL_W-1:0]    level, target;
      dir_type               last_dir, cmd_dir;
      phase_type             phase;
      logic [PWM_POS_W-1:0]  pwm_pos;
      logic [STEP_US_W-1:0]  step_us;
      logic [PRESCALE_W-1:0] prescale;
      logic [RUN_MS_W-1:0]   run_ms;
      logic [STOP_MS_W-1:0]  stop_ms;
      logic [RATE_W-1:0]     held_rate;
      logic                  motion;

      function new();
         stop_limit = STOP_MS_W'(STOP_LIMIT_RESET);
         level      = '0;
         target     = '0;
         last_dir   = DIR_CW;
         cmd_dir    = DIR_CW;
         phase      = PH_IDLE;
         pwm_pos    = '0;
         step_us    = '0;
         prescale   = '0;
         run_ms     = '0;
         stop_ms    = '0;
         held_rate  = RATE_W'(MAX_RATE);
         motion     = 1'b0;
      endfunction

      function int unsigned step_length();
         int unsigned rate;
         rate = (phase == PH_TURN) ? held_rate : RAMP_DOWN_RATE;
         return (RATE_BASE - rate) * US_PER_RATE_UNIT;
      endfunction

      function void start_step();
         motion  = 1'b1;
         step_us = '0;
         pwm_pos = '0;
         steps_taken++;
      endfunction

      // Decision taken when a command starts and whenever a step runs out.
      function void decide_step();
         if (phase == PH_REVERSE) begin
            if (stop_ms < REVERSAL_LIMIT_MS && level > 0) begin
               level = level - 1'b1;
               start_step();
               return;
            end
            motion = 1'b0;
            phase  = PH_TURN;
         end
         if (phase == PH_TURN) begin
            if (run_ms > 0) begin
               if (level > target)
                  level = level - 1'b1;
               else if (level < target)
                  level = level + 1'b1;
               start_step();
            end else begin
               last_dir = cmd_dir;
               phase    = PH_IDLE;
            end
            return;
         end
         if (phase == PH_STOP) begin
            if (stop_ms < stop_limit && level > 0) begin
               level = level - 1'b1;
               start_step();
               return;
            end
            motion = 1'b0;
            phase  = PH_IDLE;
         end
      endfunction

      function rsp_type pins_now();
         rsp_type     pins;
         dir_type     dir;
         int unsigned on_time;
         logic        pin;
         dir     = (phase == PH_TURN) ? cmd_dir : last_dir;
         on_time = (level > PWM_PERIOD) ? PWM_PERIOD : level;
         pin     = (phase != PH_IDLE) && (pwm_pos < on_time);
         pins.cw_drive    = (dir == DIR_CW) && pin;
         pins.ccw_drive   = (dir == DIR_CCW) && pin;
         pins.power_level = level;
         pins.in_motion   = motion;
         pins.busy_res    = (phase != PH_IDLE);
         return pins;
      endfunction

      function void note_item(op_type op, logic [REQ_DATA_W-1:0] data);
         rsp_type pins;
         if (op == OP_TICK) begin
            ticks++;
            pins = pins_now();
            if (phase != PH_IDLE) begin
               pwm_pos = pwm_pos + 1'b1;
               if (step_us != '1)
                  step_us = step_us + 1'b1;
               prescale = prescale + 1'b1;
               if (prescale >= TICKS_PER_MS) begin
                  prescale = '0;
                  if (run_ms > 0)
                     run_ms = run_ms - 1'b1;
                  if (stop_ms != '1)
                     stop_ms = stop_ms + 1'b1;
               end
               if (pwm_pos >= PWM_PERIOD) begin
                  pwm_pos = '0;
                  if (step_us >= step_length())
                     decide_step();
               end
            end
         end else begin
            commands++;
            if (phase == PH_IDLE && op == OP_TURN) begin
               turns_started++;
               cmd_dir   = dir_type'(data[0]);
               target    = (data[7:1] > LEVEL_CAP) ? LEVEL_W'(LEVEL_CAP) : data[7:1];
               held_rate = (data[31:28] > MAX_RATE) ? RATE_W'(MAX_RATE) : data[31:28];
               run_ms    = data[27:8];
               prescale  = '0;
               stop_ms   = '0;
               pwm_pos   = '0;
               step_us   = '0;
               if (!data[32] && cmd_dir != last_dir && level > 0) begin
                  phase = PH_REVERSE;
                  reversals++;
               end else begin
                  phase = PH_TURN;
               end
               decide_step();
            end else if (phase == PH_IDLE && op == OP_STOP && level > 0) begin
               stops_started++;
               prescale = '0;
               stop_ms  = '0;
               pwm_pos  = '0;
               step_us  = '0;
               phase    = PH_STOP;
               decide_step();
            end
            pins = pins_now();
         end
         expected_pins.push_back(pins);
      endfunction

      function void flag_field(string field, logic [15:0] want, logic [15:0] seen);
         $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
         mismatches++;
      endfunction

      function void check_pins(logic [RSP_DATA_W-1:0] got);
         rsp_type want, seen;
         if (expected_pins.size() == 0) begin
            $display("%0t: expected no result, got %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_pins.pop_front();
         seen = rsp_type'(got[$bits(rsp_type)-1:0]);
         if (seen.cw_drive !== want.cw_drive)
            flag_field("cw_drive", want.cw_drive, seen.cw_drive);
         if (seen.ccw_drive !== want.ccw_drive)
            flag_field("ccw_drive", want.ccw_drive, seen.ccw_drive);
         if (seen.power_level !== want.power_level)
            flag_field("power_level", want.power_level, seen.power_level);
         if (seen.in_motion !== want.in_motion)
            flag_field("in_motion", want.in_motion, seen.in_motion);
         if (seen.busy_res !== want.busy_res)
            flag_field("busy_res", want.busy_res, seen.busy_res);
         if (got[RSP_DATA_W-1:$bits(rsp_type)] !== '0)
            flag_field("zero fill", '0, got[RSP_DATA_W-1:$bits(rsp_type)]);
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [STOP_MS_W-1:0]  csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser   = '0;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   drive_scoreboard       board;
   int unsigned           csr_writes     = 0;
   longint unsigned       cycles         = 0;

   ramped_pwm_motor_driver_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         board.check_pins(rsp_tdata);
   end

   // Result side: a stall length is drawn for every result item.
   initial begin : result_sink
      int unsigned hold;
      wait (!reset);
      @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_command(logic dir, logic [6:0] speed,
         logic [19:0] duration, logic [3:0] rate, logic quick);
      logic [REQ_DATA_W-1:0] data;
      data        = '0;
      data[0]     = dir;
      data[7:1]   = speed;
      data[27:8]  = duration;
      data[31:28] = rate;
      data[32]    = quick;
      return data;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_command();
      return pack_command(1'($urandom), 7'($urandom), 20'($urandom), 4'($urandom),
                          1'($urandom));
   endfunction

   task automatic send_item(input op_type op, input logic [REQ_DATA_W-1:0] data);
      int unsigned gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_item(op, data);
   endtask

   task automatic send_ticks(input int unsigned count);
      repeat (count) send_item(OP_TICK, random_command());
   endtask

   // Ticks until the drive is at rest, with stray commands that it must ignore.
   task automatic run_until_still();
      while (board.phase != PH_IDLE) begin
         if ($urandom_range(0, 127) == 0)
            send_item(op_type'($urandom_range(1, 3)), random_command());
         else
            send_item(OP_TICK, random_command());
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.expected_pins.size() != 0);
   endtask

   task automatic write_stop_limit(input logic [STOP_MS_W-1:0] limit_ms);
      run_until_still();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit_ms;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.stop_limit = limit_ms;
      csr_writes++;
   endtask

   initial begin : stimulus
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle ticks, an unused code and a stop with nothing to ramp down.
      send_ticks(3);
      send_item(OP_UNUSED, pack_command(DIR_CCW, 7'h7F, 20'hFFFFF, 4'hF, 1'b1));
      send_item(OP_STOP, pack_command(DIR_CCW, 7'h7F, 20'hFFFFF, 4'hF, 1'b1));
      // Zero duration ends at once; speed and rate above their ranges saturate.
      send_item(OP_TURN, pack_command(DIR_CCW, 7'd127, 20'd0, 4'd15, 1'b0));
      write_stop_limit('0);
      // A direction change from level zero has nothing to ramp down; one full
      // step at the fastest rate follows.
      send_item(OP_TURN, pack_command(DIR_CW, 7'd127, 20'd1, 4'd15, 1'b0));
      run_until_still();
      // A zero stop limit ends the stop at once and clears the motion flag.
      send_item(OP_STOP, '0);
      write_stop_limit(STOP_MS_W'(3));
      send_item(OP_TURN, pack_command(DIR_CCW, 7'd0, 20'd0, 4'd0, 1'b1));
      // A direction change with the level up starts with a ramp-down step.
      send_item(OP_TURN, pack_command(DIR_CW, 7'd5, 20'd4, 4'd12, 1'b0));
      send_ticks(10);
      send_item(OP_STOP, random_command());
      send_item(OP_TURN, random_command());
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d ticks and %0d commands: %0d turns, %0d reversal ramp-downs,",
               board.ticks, board.commands, board.turns_started, board.reversals);
      $display("%0d stop ramps and %0d ramp steps, with %0d stop limit writes.",
               board.stops_started, board.steps_taken, csr_writes);
      if (board.mismatches == 0 && board.expected_pins.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
